// ----- src/vnr_pkg.sv -----
// vnr_pkg: word types, constants and single-precision arithmetic helpers
// for the vector normaliser; no dependencies
`default_nettype none

package vnr_pkg;

    localparam int VNR_STAGES = 14;

    localparam logic [31:0] VNR_MAGIC        = 32'h5f3759df;
    localparam logic [31:0] VNR_ONE_HALF     = 32'h3f000000;
    localparam logic [31:0] VNR_THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] VNR_EPSILON      = 32'h34000000;
    localparam logic [31:0] VNR_DEFAULT_NAN  = 32'hffc00000;
    localparam logic [31:0] VNR_QUIET_BIT    = 32'h00400000;

    localparam logic [2:0] VNR_LEN_MIN   = 3'd2;
    localparam logic [2:0] VNR_LEN_MAX   = 3'd4;
    localparam logic [2:0] VNR_LEN_RESET = 3'd3;

    typedef struct packed {
        logic [31:0] comp_x;
        logic [31:0] comp_y;
        logic [31:0] comp_z;
        logic [31:0] comp_w;
    } vnr_in_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_w;
        logic        ok;
    } vnr_out_t;

    typedef struct packed {
        logic [3:0][31:0] comp;
        logic [3:0][31:0] sq;
        logic [2:0]       len;
        logic             good;
        logic [31:0]      acc;
        logic [31:0]      h;
        logic [31:0]      y;
        logic [31:0]      u;
    } vnr_stage_t;

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    // value = m * 2^(e - 175); normalise, round to nearest even, pack
    function automatic logic [31:0] fp_round(input logic s, input int e,
                                             input logic [49:0] m);
        int          lz;
        int          ex;
        int          sh;
        logic [49:0] n;
        logic        st;
        logic        g;
        logic [24:0] r;
        logic [30:0] mag;
        lz = 50;
        for (int i = 0; i < 50; i++)
            if (m[i])
                lz = 49 - i;
        if (m == 50'd0)
            return {s, 31'd0};
        n  = m << lz;
        ex = e + 1 - lz;
        st = 1'b0;
        if (ex >= 255)
            return {s, 8'hff, 23'd0};
        if (ex <= 0)
        begin
            sh = 1 - ex;
            if (sh > 49)
            begin
                st = |n;
                n  = 50'd0;
            end
            else
            begin
                st = |(n & ((50'd1 << sh) - 50'd1));
                n  = n >> sh;
            end
            ex = 0;
        end
        g  = n[25];
        st = st | (|n[24:0]);
        r  = {1'b0, n[49:26]};
        if (g && (st || r[0]))
            r = r + 25'd1;
        if (ex == 0)
            return {s, 6'd0, r};
        mag = {8'(ex - 1), 23'd0} + {6'd0, r};
        return {s, mag};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        int          ea;
        int          eb;
        s = a[31] ^ b[31];
        if (is_nan(a))
            return a | VNR_QUIET_BIT;
        if (is_nan(b))
            return b | VNR_QUIET_BIT;
        if (is_inf(a) || is_inf(b))
        begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
                return VNR_DEFAULT_NAN;
            return {s, 8'hff, 23'd0};
        end
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        p  = ma * mb;
        return fp_round(s, ea + eb - 125, {2'b00, p});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic [49:0] am;
        logic [49:0] bm;
        logic [49:0] sum;
        logic        st;
        int          eb;
        int          es;
        int          d;
        if (is_nan(a))
            return a | VNR_QUIET_BIT;
        if (is_nan(b))
            return b | VNR_QUIET_BIT;
        if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
            return VNR_DEFAULT_NAN;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b;
        if (a[30:0] < b[30:0])
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        eb = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
        es = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
        d  = eb - es;
        am = {2'b00, big[30:23] != 8'd0, big[22:0], 24'd0};
        bm = {2'b00, sml[30:23] != 8'd0, sml[22:0], 24'd0};
        if (d > 49)
        begin
            st = |bm;
            bm = 50'd0;
        end
        else
        begin
            st = |(bm & ((50'd1 << d) - 50'd1));
            bm = bm >> d;
        end
        bm[0] = bm[0] | st;
        if (big[31] == sml[31])
            sum = am + bm;
        else
            sum = am - bm;
        if (sum == 50'd0)
            return {big[31] & sml[31], 31'd0};
        return fp_round(big[31], eb + 1, sum);
    endfunction

endpackage

`default_nettype wire

// ----- src/vnr_flow.sv -----
// vnr_flow: valid bits and per-stage enables of the normaliser pipeline
// depends on vnr_pkg
`default_nettype none

module vnr_flow
    import vnr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  src_valid,
    input  wire logic                  dst_stall,
    output logic                       src_stall,
    output logic [VNR_STAGES:1]        stage_valid,
    output logic [VNR_STAGES:1]        stage_en
);

    logic [VNR_STAGES:1] valid_reg;
    logic [VNR_STAGES:1] valid_next;
    logic [VNR_STAGES:0] feed;

    // a stage may load when it is empty or its word moves on
    always_comb
    begin
        stage_en[VNR_STAGES] = !valid_reg[VNR_STAGES] || !dst_stall;
        for (int k = VNR_STAGES - 1; k >= 1; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
    end

    always_comb
    begin
        feed = {valid_reg, src_valid};
        for (int k = 1; k <= VNR_STAGES; k++)
            valid_next[k] = stage_en[k] ? feed[k - 1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign src_stall   = !stage_en[1];
    assign stage_valid = valid_reg;

endmodule

`default_nettype wire

// ----- src/vector_normalize_fast_rsqrt.sv -----
// vector_normalize_fast_rsqrt: normalises a 2 to 4 component single-precision
// vector with a magic-constant seed and two newton steps
// depends on vnr_pkg and vnr_flow
//
// usage: a word on src_word is taken when src_valid is high and src_stall
// low; the result word leaves on dst_word under dst_valid / dst_stall.
// cfg_we with cfg_data sets the component count (2..4, reset 3); it is to be
// written only while the block is empty, which the block itself does not enforce.
// the pipeline does one step per stage (squares, three adds, seed, two newton
// steps of four stages, scaling), 14 stages in all.
// throughput: one word per cycle while the receiver does not stall.
// reset empties the pipeline and sets the count to 3.
// when the receiver stalls, the last stage holds its word and bubbles in
// front of it close up; src_stall rises only once every stage is full.
`default_nettype none

module vector_normalize_fast_rsqrt
    import vnr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     src_valid,
    output logic          src_stall,
    input  wire vnr_in_t  src_word,
    output logic          dst_valid,
    input  wire logic     dst_stall,
    output vnr_out_t      dst_word,
    input  wire logic     cfg_we,
    input  wire logic [2:0] cfg_data
);

    logic [2:0]          len_reg;
    logic [2:0]          len_eff;
    logic [VNR_STAGES:1] stage_valid;
    logic [VNR_STAGES:1] stage_en;
    vnr_stage_t          pipe_reg  [VNR_STAGES:1];
    vnr_stage_t          pipe_next [VNR_STAGES:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= VNR_LEN_RESET;
        else if (cfg_we)
            len_reg <= cfg_data;
    end

    always_comb
    begin
        if (len_reg < VNR_LEN_MIN)
            len_eff = VNR_LEN_MIN;
        else if (len_reg > VNR_LEN_MAX)
            len_eff = VNR_LEN_MAX;
        else
            len_eff = len_reg;
    end

    vnr_flow u_flow (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .dst_stall   (dst_stall),
        .src_stall   (src_stall),
        .stage_valid (stage_valid),
        .stage_en    (stage_en)
    );

    // squares and finiteness check
    always_comb
    begin
        pipe_next[1]         = '0;
        pipe_next[1].comp[0] = src_word.comp_x;
        pipe_next[1].comp[1] = src_word.comp_y;
        pipe_next[1].comp[2] = src_word.comp_z;
        pipe_next[1].comp[3] = src_word.comp_w;
        pipe_next[1].len     = len_eff;
        pipe_next[1].good    = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            pipe_next[1].sq[i] = fp_mul(pipe_next[1].comp[i], pipe_next[1].comp[i]);
            if (3'(i) < len_eff && pipe_next[1].comp[i][30:23] == 8'hff)
                pipe_next[1].good = 1'b0;
        end
    end

    genvar k;
    generate
        for (k = 2; k <= VNR_STAGES; k++)
        begin : g_stage
            always_comb
            begin
                pipe_next[k] = pipe_reg[k - 1];
                if (k == 2)
                    pipe_next[k].acc = fp_add(pipe_reg[k - 1].sq[0], pipe_reg[k - 1].sq[1]);
                else if (k == 3)
                begin
                    if (pipe_reg[k - 1].len >= 3'd3)
                        pipe_next[k].acc = fp_add(pipe_reg[k - 1].acc, pipe_reg[k - 1].sq[2]);
                end
                else if (k == 4)
                begin
                    if (pipe_reg[k - 1].len == VNR_LEN_MAX)
                        pipe_next[k].acc = fp_add(pipe_reg[k - 1].acc, pipe_reg[k - 1].sq[3]);
                end
                else if (k == 5)
                begin
                    if (pipe_reg[k - 1].acc < VNR_EPSILON)
                        pipe_next[k].good = 1'b0;
                    pipe_next[k].h = fp_mul(VNR_ONE_HALF, pipe_reg[k - 1].acc);
                    pipe_next[k].y = VNR_MAGIC - {1'b0, pipe_reg[k - 1].acc[31:1]};
                end
                else if (k == VNR_STAGES)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) >= pipe_reg[k - 1].len)
                            pipe_next[k].comp[i] = 32'd0;
                        else if (pipe_reg[k - 1].good)
                            pipe_next[k].comp[i] = fp_mul(pipe_reg[k - 1].comp[i],
                                                          pipe_reg[k - 1].y);
                    end
                end
                else if ((k - 6) % 4 == 0)
                    pipe_next[k].u = fp_mul(pipe_reg[k - 1].h, pipe_reg[k - 1].y);
                else if ((k - 6) % 4 == 1)
                    pipe_next[k].u = fp_mul(pipe_reg[k - 1].u, pipe_reg[k - 1].y);
                else if ((k - 6) % 4 == 2)
                    pipe_next[k].u = fp_add(VNR_THREE_HALVES,
                                            {~pipe_reg[k - 1].u[31], pipe_reg[k - 1].u[30:0]});
                else
                    pipe_next[k].y = fp_mul(pipe_reg[k - 1].y, pipe_reg[k - 1].u);
            end
        end
    endgenerate

    generate
        for (k = 1; k <= VNR_STAGES; k++)
        begin : g_reg
            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                    pipe_reg[k] <= pipe_next[k];
            end
        end
    endgenerate

    assign dst_valid      = stage_valid[VNR_STAGES];
    assign dst_word.out_x = pipe_reg[VNR_STAGES].comp[0];
    assign dst_word.out_y = pipe_reg[VNR_STAGES].comp[1];
    assign dst_word.out_z = pipe_reg[VNR_STAGES].comp[2];
    assign dst_word.out_w = pipe_reg[VNR_STAGES].comp[3];
    assign dst_word.ok    = pipe_reg[VNR_STAGES].good;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (dst_valid && dst_stall))
        else $error("input stalled while the pipeline has room");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> stage_valid[1])
        else $error("accepted word lost at the first stage");

    a_unused_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_word.out_w != 32'd0) |-> (pipe_reg[VNR_STAGES].len == VNR_LEN_MAX))
        else $error("fourth component non-zero for a shorter vector");

endmodule

`default_nettype wire
